// File: sv/edd555_pkg.sv
// Package for the RGB555 error diffusion core: shared widths, tables and arithmetic.
`timescale 1ns / 1ps
`default_nettype none

package edd555_pkg;

  localparam int unsigned CHAN_W   = 8;
  localparam int unsigned ERR_W    = 4;
  localparam int unsigned NUM_CHAN = 3;
  localparam int unsigned ERRS_W   = ERR_W * NUM_CHAN;
  localparam int unsigned LEVEL_W  = 5;

  // register indices (index 0 at byte offset 0)
  localparam logic REG_IMAGE_WIDTH = 1'b0;
  localparam logic [11:0] IMAGE_WIDTH_RESET = 12'd640;

  // diffusion weights
  localparam logic [2:0] W_UPPER_LEFT  = 3'd1;
  localparam logic [2:0] W_UPPER       = 3'd5;
  localparam logic [2:0] W_UPPER_RIGHT = 3'd3;
  localparam logic [2:0] W_LEFT        = 3'd7;

  // three packed signed channel errors: blue [3:0], green [7:4], red [11:8]
  typedef logic [ERRS_W-1:0] errs_t;

  // floor(q * 255 / 31) for every 5-bit level
  localparam logic [CHAN_W-1:0] QLEVEL [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // clamp(trunc_toward_zero((16*v + e*w) / 16), 0, 255)
  function automatic logic [CHAN_W-1:0] diffuse(input logic [CHAN_W-1:0] v,
                                                input logic signed [ERR_W-1:0] e,
                                                input logic [2:0] w);
    logic signed [7:0]  p;
    logic signed [13:0] t;
    logic signed [13:0] qd;
    logic [CHAN_W-1:0]  r;
    p  = e * $signed({1'b0, w});
    t  = $signed({2'b00, v, 4'b0000}) + $signed({{6{p[7]}}, p});
    if (t < 0) begin
      qd = (t + 14'sd15) >>> 4;
    end else begin
      qd = t >>> 4;
    end
    if (qd < 0) begin
      r = '0;
    end else if (qd > 14'sd255) begin
      r = 8'd255;
    end else begin
      r = qd[CHAN_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// File: sv/error_diffusion_dither_rgb555_core.sv
// Top level of the streaming RGB888 to RGB555 error diffusion core.
// Path: an accepted request is registered in stage 1, then stage 2, then the
// output register. Throughput: one pixel per clock while the output is not stalled, for
// rows of four or more pixels; narrower rows stall input until the row-error memory entry a
// pixel needs has been written back (two-stage read-modify-write loop on one memory).
// Reset: position and held errors are cleared, the first-row flag is set and width returns
// to 640 at once; the row-error memory is not cleared and is written by the first row.
`timescale 1ns / 1ps
`default_nettype none

module error_diffusion_dither_rgb555_core #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // pixel input
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [edd555_pkg::CHAN_W-1:0] blue_in_i,
  input  wire logic [edd555_pkg::CHAN_W-1:0] green_in_i,
  input  wire logic [edd555_pkg::CHAN_W-1:0] red_in_i,
  input  wire logic        frame_start_i,
  // pixel output
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [14:0]      pixel_rgb555_o,
  output logic             row_last_o
);

  import edd555_pkg::*;

  localparam int unsigned AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned CW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned EW = (CW > 12) ? CW : 12;

  // configuration
  logic [11:0] width_q, width_d;
  logic        cfg_wr;

  // input side position tracking
  logic [AW-1:0] col_q, col_d;
  logic          first_q, first_d;
  logic [AW-1:0] c_now, ra1;
  logic          first_now, last_now;
  logic [EW-1:0] wcfg, weff, cnext;
  logic          hazard, accept;

  // stage 1: memory read data arrives
  logic          valid1_q;
  logic [AW-1:0] c1_q;
  logic          last1_q, first1_q;
  logic [CHAN_W-1:0] pix1_q [NUM_CHAN];
  errs_t         rd0_q, rd1_q;
  errs_t         held_q;
  logic [CHAN_W-1:0] vup [NUM_CHAN];

  // stage 2: left neighbor and quantize
  logic          valid2_q;
  logic [AW-1:0] c2_q;
  logic          last2_q, nz2_q;
  logic [CHAN_W-1:0] vup2_q [NUM_CHAN];
  errs_t         left_q;
  errs_t         err2;
  logic [LEVEL_W-1:0] lev2 [NUM_CHAN];

  // output register
  logic          out_valid_q;
  logic [14:0]   pix_out_q;
  logic          row_last_q;

  // row error memory
  errs_t         mem [MAX_WIDTH];

  // flow control
  logic s3_free, s2_free, s1_free, mv1, mv2;

  // configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IMAGE_WIDTH);
  assign width_d = cfg_wr ? pwdata[11:0] : width_q;
  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_IMAGE_WIDTH) begin
      prdata = {20'd0, width_q};
    end
  end

  // advance each stage when the one after it can take the item
  assign s3_free = !out_valid_q || !out_stall_i;
  assign mv2     = valid2_q && s3_free;
  assign s2_free = !valid2_q || s3_free;
  assign mv1     = valid1_q && s2_free;
  assign s1_free = !valid1_q || s2_free;

  // column position and row end of the incoming pixel
  always_comb begin
    c_now     = frame_start_i ? '0 : col_q;
    first_now = frame_start_i ? 1'b1 : first_q;
    wcfg      = EW'(width_q);
    if (wcfg == '0) begin
      weff = EW'(1);
    end else if (wcfg > EW'(MAX_WIDTH)) begin
      weff = EW'(MAX_WIDTH);
    end else begin
      weff = wcfg;
    end
    cnext    = EW'(c_now) + EW'(1);
    last_now = (cnext >= weff);
    ra1      = c_now + AW'(1);
  end

  // interlock: hold the request while an older pixel still owes a write to an entry it reads
  always_comb begin
    hazard = 1'b0;
    if (!first_now) begin
      if (valid1_q && ((c1_q == c_now) || (!last_now && (c1_q == ra1)))) begin
        hazard = 1'b1;
      end
      if (valid2_q && ((c2_q == c_now) || (!last_now && (c2_q == ra1)))) begin
        hazard = 1'b1;
      end
    end
  end

  assign in_stall_o = !s1_free || hazard;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    col_d   = col_q;
    first_d = first_q;
    if (accept) begin
      col_d   = last_now ? '0 : ra1;
      first_d = last_now ? 1'b0 : first_now;
    end
  end

  // stage 1 arithmetic: upper-left, upper, upper-right adjustments
  always_comb begin
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      vup[ch] = pix1_q[ch];
      if (!first1_q) begin
        if (c1_q != '0) begin
          vup[ch] = diffuse(vup[ch], held_q[ch*ERR_W +: ERR_W], W_UPPER_LEFT);
        end
        vup[ch] = diffuse(vup[ch], rd0_q[ch*ERR_W +: ERR_W], W_UPPER);
        if (!last1_q) begin
          vup[ch] = diffuse(vup[ch], rd1_q[ch*ERR_W +: ERR_W], W_UPPER_RIGHT);
        end
      end
    end
  end

  // stage 2 arithmetic: left adjustment, quantize, new error
  always_comb begin
    logic [CHAN_W-1:0] v;
    logic [CHAN_W:0]   diff;
    for (int ch = 0; ch < NUM_CHAN; ch++) begin
      v = vup2_q[ch];
      if (nz2_q) begin
        v = diffuse(v, left_q[ch*ERR_W +: ERR_W], W_LEFT);
      end
      lev2[ch] = v[CHAN_W-1:3];
      diff = {1'b0, v} - {1'b0, QLEVEL[v[CHAN_W-1:3]]};
      err2[ch*ERR_W +: ERR_W] = diff[ERR_W-1:0];
    end
  end

  // row error memory: read on accept, write back when stage 2 retires
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd0_q <= mem[c_now];
      rd1_q <= mem[ra1];
    end
    if (mv2) begin
      mem[c2_q] <= err2;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      c1_q      <= c_now;
      last1_q   <= last_now;
      first1_q  <= first_now;
      pix1_q[0] <= blue_in_i;
      pix1_q[1] <= green_in_i;
      pix1_q[2] <= red_in_i;
    end
    if (mv1) begin
      c2_q    <= c1_q;
      last2_q <= last1_q;
      nz2_q   <= (c1_q != '0);
      for (int ch = 0; ch < NUM_CHAN; ch++) begin
        vup2_q[ch] <= vup[ch];
      end
    end
    if (mv2) begin
      pix_out_q  <= {lev2[2], lev2[1], lev2[0]};
      row_last_q <= last2_q;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q     <= IMAGE_WIDTH_RESET;
      col_q       <= '0;
      first_q     <= 1'b1;
      held_q      <= '0;
      left_q      <= '0;
      valid1_q    <= 1'b0;
      valid2_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      width_q <= width_d;
      col_q   <= col_d;
      first_q <= first_d;
      if (mv1) begin
        held_q <= rd0_q;
      end
      if (mv2) begin
        left_q <= err2;
      end
      if (s1_free) begin
        valid1_q <= accept;
      end
      if (s2_free) begin
        valid2_q <= mv1;
      end
      if (s3_free) begin
        out_valid_q <= mv2;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_rgb555_o = pix_out_q;
  assign row_last_o     = row_last_q;

  // an older pixel in stage 2 never writes an entry the stage 1 pixel has read
  a_no_stale_read : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid1_q && valid2_q && !first1_q) |->
      ((c2_q != c1_q) && (last1_q || (c2_q != (c1_q + AW'(1))))))
    else $error("stage 1 read an entry still owed by stage 2");

  // a row-ending pixel restarts the column count
  a_row_wrap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && last_now) |=> (col_q == '0) && !first_q)
    else $error("column did not wrap after last pixel of a row");

  // a retiring stage 2 pixel lands in the output register
  a_retire : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mv2 |=> out_valid_q)
    else $error("retired pixel missing from output register");

endmodule

`default_nettype wire

// File: tb/error_diffusion_dither_rgb555_core_tb.sv
// Testbench for the RGB555 error diffusion core: directed table, then random frames.
`timescale 1ns / 1ps
`default_nettype none

module error_diffusion_dither_rgb555_core_tb;
  import edd555_pkg::*;

  localparam int MAX_W = 2048;
  localparam int HALF_PERIOD = 4;
  localparam int RESET_CYCLES = 10;
  localparam int DRAIN_CYCLES = 10;
  localparam int WIDE_ITEMS = 64;
  localparam int RANDOM_ITEMS = 1000;
  localparam longint CYCLE_LIMIT = 1500000;
  // byte address of the width register: four bytes per register index
  localparam logic [2:0] IMAGE_WIDTH_ADDR = 3'(4 * int'(REG_IMAGE_WIDTH));

  typedef struct {
    logic [14:0] pix;
    logic        last;
  } dither_out_t;

  typedef struct {
    bit          reprogram;
    logic [11:0] new_width;
    bit          fs;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    bit          typed;
    logic [14:0] pix;
    bit          last;
  } stim_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic [CHAN_W-1:0] blue_in_i = '0;
  logic [CHAN_W-1:0] green_in_i = '0;
  logic [CHAN_W-1:0] red_in_i = '0;
  logic              frame_start_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic [14:0]       pixel_rgb555_o;
  logic              row_last_o;

  error_diffusion_dither_rgb555_core #(.MAX_WIDTH(MAX_W)) dut (.*);

  always #HALF_PERIOD clk_i = ~clk_i;

  // predictor state: width setting, previous-row errors, scan position
  logic [11:0] width_reg = IMAGE_WIDTH_RESET;
  byte         row_err [MAX_W][3];
  int          col_pos = 0;
  bit          first_row = 1'b1;
  byte         left_err [3] = '{0, 0, 0};
  byte         upper_left_err [3] = '{0, 0, 0};

  dither_out_t pending_pixels [$];
  int          mismatches = 0;
  int          quiet_in = 0;
  longint      cycle_cnt = 0;

  // directed requests; the expected word is typed in only where it is obvious
  stim_row_t directed_rows [27] = '{
    '{0, 12'd0,    1, 8'h00, 8'h00, 8'h00, 1, 15'h0000, 0},
    '{0, 12'd0,    0, 8'hFF, 8'hFF, 8'hFF, 1, 15'h7FFF, 0},
    '{1, 12'd3,    1, 8'h00, 8'h00, 8'h00, 1, 15'h0000, 0},
    '{0, 12'd0,    0, 8'hFF, 8'hFF, 8'hFF, 1, 15'h7FFF, 0},
    '{0, 12'd0,    0, 8'h00, 8'h00, 8'h00, 1, 15'h0000, 1},
    '{0, 12'd0,    0, 8'hFF, 8'hFF, 8'hFF, 1, 15'h7FFF, 0},
    '{0, 12'd0,    0, 8'h00, 8'h00, 8'h00, 1, 15'h0000, 0},
    '{0, 12'd0,    0, 8'hFF, 8'hFF, 8'hFF, 1, 15'h7FFF, 1},
    '{0, 12'd0,    1, 8'h08, 8'h08, 8'h08, 1, 15'h0421, 0},
    '{0, 12'd0,    0, 8'h07, 8'h84, 8'hF8, 0, 15'h0000, 0},
    '{0, 12'd0,    0, 8'h7F, 8'h80, 8'h01, 0, 15'h0000, 0},
    '{0, 12'd0,    0, 8'h0F, 8'hF0, 8'h33, 0, 15'h0000, 0},
    '{0, 12'd0,    0, 8'hC3, 8'h3C, 8'h99, 0, 15'h0000, 0},
    '{0, 12'd0,    0, 8'h01, 8'hFF, 8'h00, 0, 15'h0000, 0},
    '{0, 12'd0,    0, 8'h21, 8'h42, 8'h84, 0, 15'h0000, 0},
    // frame start in the middle of a row
    '{0, 12'd0,    1, 8'hE7, 8'h18, 8'h66, 0, 15'h0000, 0},
    // widen during the first row
    '{1, 12'd5,    0, 8'h05, 8'h06, 8'h07, 0, 15'h0000, 0},
    '{0, 12'd0,    0, 8'hF9, 8'hFA, 8'hFB, 0, 15'h0000, 0},
    '{0, 12'd0,    0, 8'h80, 8'h80, 8'h80, 0, 15'h0000, 0},
    '{0, 12'd0,    0, 8'h00, 8'hFF, 8'h7F, 0, 15'h0000, 0},
    '{0, 12'd0,    0, 8'h04, 8'h03, 8'h02, 0, 15'h0000, 0},
    '{0, 12'd0,    0, 8'h81, 8'h7E, 8'h3F, 0, 15'h0000, 0},
    '{0, 12'd0,    0, 8'hBF, 8'h40, 8'h9C, 0, 15'h0000, 0},
    // narrow mid-row: the column lies beyond the new width, so the row ends
    '{1, 12'd2,    0, 8'h10, 8'hEF, 8'h20, 0, 15'h0000, 0},
    // width zero acts as one pixel per row
    '{1, 12'd0,    1, 8'hFF, 8'h00, 8'h80, 1, 15'h401F, 1},
    '{0, 12'd0,    0, 8'hFF, 8'hFF, 8'hFF, 0, 15'h0000, 0},
    '{1, 12'hFFF,  1, 8'h00, 8'h00, 8'h00, 1, 15'h0000, 0}
  };

  // clamp(trunc((16v + e*w) / 16)) to the channel range
  function automatic int spread_error(input int v, input int e, input int w);
    int t;
    t = (16 * v + e * w) / 16;
    if (t > 255) t = 255;
    if (t < 0) t = 0;
    return t;
  endfunction

  // advance the predictor by one pixel and return its RGB555 word
  function automatic dither_out_t dither_pixel(input logic [7:0] blue, input logic [7:0] green,
                                               input logic [7:0] red, input bit fs);
    int          eff_w;
    int          c;
    int          v;
    int          above;
    int          err;
    int          raw [3];
    int          lvl [3];
    bit          last;
    dither_out_t res;
    raw = '{int'(blue), int'(green), int'(red)};
    if (width_reg == 0) eff_w = 1;
    else if (width_reg > MAX_W) eff_w = MAX_W;
    else eff_w = int'(width_reg);
    if (fs) begin
      col_pos = 0;
      first_row = 1'b1;
      left_err = '{0, 0, 0};
      upper_left_err = '{0, 0, 0};
    end
    c = col_pos % MAX_W;
    last = (c + 1 >= eff_w);
    for (int ch = 0; ch < 3; ch++) begin
      v = raw[ch];
      above = row_err[c][ch];
      if (!first_row) begin
        if (c > 0) v = spread_error(v, upper_left_err[ch], int'(W_UPPER_LEFT));
        v = spread_error(v, above, int'(W_UPPER));
        if (!last) v = spread_error(v, row_err[c + 1][ch], int'(W_UPPER_RIGHT));
      end
      if (c > 0) v = spread_error(v, left_err[ch], int'(W_LEFT));
      lvl[ch] = v >> 3;
      err = v - (lvl[ch] * 255) / 31;
      upper_left_err[ch] = byte'(above);
      row_err[c][ch] = byte'(err);
      left_err[ch] = byte'(err);
    end
    res.pix = 15'((lvl[2] << 10) | (lvl[1] << 5) | lvl[0]);
    res.last = last;
    if (last) begin
      col_pos = 0;
      first_row = 1'b0;
    end else begin
      col_pos = c + 1;
    end
    return res;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endtask

  // one APB transfer: setup, access, then idle with the select dropped
  task automatic apb_access(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= wr;
    paddr <= IMAGE_WIDTH_ADDR;
    pwdata <= wdata;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // write the width, mirror it in the predictor, read it back
  task automatic program_width(input logic [11:0] w);
    logic [31:0] rd;
    apb_access(1'b1, 32'(w), rd);
    width_reg = w;
    apb_access(1'b0, '0, rd);
    if (rd[11:0] !== w)
      flag_mismatch($sformatf("width readback expected %0d got %0d", w, rd[11:0]));
  endtask

  // drop valid and wait until every pixel in flight has come out
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // hand one request to the core and record the word it must produce
  task automatic send_pixel(input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                            input bit fs, input bit typed, input logic [14:0] tpix,
                            input bit tlast);
    int          gap;
    int          pick;
    dither_out_t got;
    gap = 0;
    if (quiet_in > 0) begin
      quiet_in--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 5) quiet_in = $urandom_range(40, 200);
      else if (pick < 25) gap = $urandom_range(1, 3);
      else if (pick < 31) gap = $urandom_range(6, 30);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    blue_in_i <= b;
    green_in_i <= g;
    red_in_i <= r;
    frame_start_i <= fs;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    got = dither_pixel(b, g, r, fs);
    if (typed) begin
      got.pix = tpix;
      got.last = tlast;
    end
    pending_pixels.push_back(got);
  endtask

  // lean toward the ends of the range, where clamping happens
  function automatic logic [7:0] random_channel();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 12) return 8'($urandom_range(0, 7));
    if (pick < 24) return 8'($urandom_range(248, 255));
    return 8'($urandom_range(0, 255));
  endfunction

  // a frame opens the run; stray frame starts land anywhere in it
  task automatic send_random_run(input int count);
    for (int i = 0; i < count; i++)
      send_pixel(random_channel(), random_channel(), random_channel(),
                 (i == 0) || ($urandom_range(0, 49) == 0), 1'b0, '0, 1'b0);
  endtask

  // compare each accepted output word with the oldest pending pixel
  always @(posedge clk_i) begin : check_output
    dither_out_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_pixels.size() == 0) begin
        flag_mismatch($sformatf("unexpected pixel %h last %b", pixel_rgb555_o, row_last_o));
      end else begin
        want = pending_pixels.pop_front();
        if (pixel_rgb555_o !== want.pix)
          flag_mismatch($sformatf("pixel expected %h got %h", want.pix, pixel_rgb555_o));
        if (row_last_o !== want.last)
          flag_mismatch($sformatf("row_last expected %b got %b", want.last, row_last_o));
      end
    end
  end

  // output back-pressure: short and long stalls with quiet stretches
  initial begin : stall_gen
    int pick;
    @(posedge clk_i);
    forever begin
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(50, 300)) @(posedge clk_i);
      end else if (pick < 55) begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end else if (pick < 90) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(6, 40)) @(posedge clk_i);
      end
    end
  end

  // hard stop if the run hangs
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("error_diffusion_dither_rgb555_core_tb: FAIL");
      $finish;
    end
  end

  initial begin : main_seq
    logic [31:0] rd;
    int          w;
    int          rows;
    int          count;
    int          pick;
    int          random_items;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    apb_access(1'b0, '0, rd);
    if (rd[11:0] !== IMAGE_WIDTH_RESET)
      flag_mismatch($sformatf("width after reset expected %0d got %0d",
                              IMAGE_WIDTH_RESET, rd[11:0]));

    // directed table
    foreach (directed_rows[i]) begin
      if (directed_rows[i].reprogram) begin
        settle();
        program_width(directed_rows[i].new_width);
      end
      send_pixel(directed_rows[i].blue, directed_rows[i].green, directed_rows[i].red,
                 directed_rows[i].fs, directed_rows[i].typed, directed_rows[i].pix,
                 directed_rows[i].last);
    end

    // a stretch of the first row at the widest setting
    settle();
    program_width(12'(MAX_W));
    send_random_run(WIDE_ITEMS);

    // random frames, mostly narrow
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) w = 1;
      else if (pick < 16) w = 2;
      else if (pick < 24) w = 3;
      else if (pick < 60) w = $urandom_range(4, 12);
      else if (pick < 92) w = $urandom_range(13, 64);
      else w = $urandom_range(65, 300);
      rows = (w > 64) ? 2 : $urandom_range(2, 6);
      count = rows * w + $urandom_range(0, w - 1);
      settle();
      program_width(12'(w));
      send_random_run(count);
      random_items += count;
    end

    settle();
    if (mismatches == 0) begin
      $display("error_diffusion_dither_rgb555_core_tb: PASS");
    end else begin
      $display("error_diffusion_dither_rgb555_core_tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
